@@ rtl/core/urc_pkg.sv @@
`default_nettype none

package urc_pkg;

    localparam int COUNT_BITS_DEFAULT = 16;

    localparam int TICK_W = 20;
    localparam int DIST_W = 11;
    localparam int DIGIT_W = 4;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W = 20;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 32;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_TICKS = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLDOFF_TICKS = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_DISTANCE = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ALARM_DISTANCE = 8'd3;

    localparam logic [TICK_W-1:0] TRIGGER_TICKS_RST = 20'd4608;
    localparam logic [TICK_W-1:0] HOLDOFF_TICKS_RST = 20'd73728;
    localparam logic [DIST_W-1:0] MAX_DISTANCE_RST = 11'd700;
    localparam logic [DIST_W-1:0] ALARM_DISTANCE_RST = 11'd100;

    // count width wide enough for any legal count
    localparam int CNT_EXT_W = 25;
    // smallest count whose distance no longer fits in DIST_W bits
    localparam logic [CNT_EXT_W-1:0] SAT_COUNT = 25'd120471;
    localparam int CNT_LOW_W = 17;
    localparam int X_W = 21;
    localparam logic [DIST_W-1:0] DIST_MAX = 11'd2047;

    // floor(x / 1000) = (x * RECIP_1000) >> 31 for x below 2^21
    localparam logic [21:0] RECIP_1000 = 22'd2147484;
    // floor(d / 100) = (d * 5243) >> 19, floor(d / 10) = (d * 52429) >> 19
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam logic [15:0] RECIP_10 = 16'd52429;
    // floor(q / 10) = (q * 205) >> 11 for q below 1029
    localparam logic [7:0] RECIP_10_SMALL = 8'd205;

    typedef struct packed {
        logic trig;
        logic done;
        logic ovf;
        logic sat;
        logic [X_W-1:0] x;
    } urc_s2_t;

    typedef struct packed {
        logic trig;
        logic done;
        logic ovf;
        logic [DIST_W-1:0] dist_cm;
    } urc_s3_t;

    typedef struct packed {
        logic trig;
        logic done;
        logic over;
        logic alarm;
        logic [DIST_W-1:0] dist_cm;
        logic [4:0] q100;
        logic [7:0] q10;
    } urc_s4_t;

endpackage

`default_nettype wire

@@ rtl/core/ultrasonic_range_controller_unit.sv @@
`default_nettype none

// Ultrasonic echo ranging controller. Every input request is one timer tick
// carrying the sampled echo level in s_tdata[0]; every tick yields exactly one
// result request with the trigger pin level and, on the tick the echo falls,
// the distance in cm (count * 17 / 1000, truncated, saturating at 2047), its
// three decimal digits, an overrange flag and a proximity alarm that is
// suppressed when the echo counter wrapped. One tick is accepted every clock
// cycle while m_tready stays high, and each result passes six registers: an
// input register, the phase sequencer, the scaling by 17, the reciprocal
// multiply for the division by 1000, the digit reciprocals, and the result
// register. Each stage holds its request on its own, so bubbles close up and
// the input side keeps taking ticks while a finished result waits, until
// every stage is full.
// Configuration writes (index 0 trigger_ticks, 1 holdoff_ticks,
// 2 max_distance, 3 alarm_distance; other indexes are ignored) are always
// accepted and must only be issued while the pipeline is empty.
module ultrasonic_range_controller_unit
    import urc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // fields from bit 0: echo, zero fill
    input  wire logic [S_DATA_W-1:0]    s_tdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // fields from bit 0: trigger, distance_cm, digit_hundreds, digit_tens,
    // digit_ones, overrange, alarm, zero fill
    output logic [M_DATA_W-1:0]         m_tdata,
    // fields from bit 0: done_res
    output logic                        m_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [1:0] PH_TRIGGER = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_COUNT = 2'd2;
    localparam logic [1:0] PH_HOLDOFF = 2'd3;

    // configuration registers
    logic [TICK_W-1:0] trigger_ticks_reg;
    logic [TICK_W-1:0] holdoff_ticks_reg;
    logic [DIST_W-1:0] max_distance_reg;
    logic [DIST_W-1:0] alarm_distance_reg;

    // sequencer state
    logic [1:0]            phase_reg, phase_next;
    logic [TICK_W-1:0]     pt_reg, pt_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  ovf_reg, ovf_next;

    // pipeline valids and payloads
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy0, rdy1, rdy2, rdy3, rdy4, rdy5;

    logic                  echo_reg;
    logic                  trig1_reg, done1_reg, ovf1_reg;
    logic [COUNT_BITS-1:0] cnt1_reg;
    urc_s2_t               s2_reg, s2_next;
    urc_s3_t               s3_reg, s3_next;
    urc_s4_t               s4_reg, s4_next;
    logic [M_DATA_W-1:0]   tdata_reg, tdata_next;
    logic                  tuser_reg;

    logic                  trig_c, done_c;
    logic [TICK_W-1:0]     pt_inc;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  st_en;

    logic [X_W-1:0]        c_low;
    logic [42:0]           prod_1000;
    logic [23:0]           prod_100;
    logic [26:0]           prod_10;
    logic [15:0]           prod_t;
    logic [4:0]            tens_q;
    logic [DIGIT_W-1:0]    dig_h, dig_t, dig_o;
    logic [DIST_W-1:0]     q10_x10;
    logic [7:0]            tq_x10;

    // ready ripples back from the result register; an empty stage always takes
    assign rdy5 = !v5_reg || m_tready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign rdy0 = !v0_reg || rdy1;

    assign s_tready = rdy0;
    assign cfg_ready = 1'b1;
    assign st_en = v0_reg && rdy1;

    // configuration writes; drop unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trigger_ticks_reg <= TRIGGER_TICKS_RST;
            holdoff_ticks_reg <= HOLDOFF_TICKS_RST;
            max_distance_reg <= MAX_DISTANCE_RST;
            alarm_distance_reg <= ALARM_DISTANCE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TRIGGER_TICKS:  trigger_ticks_reg <= cfg_data;
                REG_HOLDOFF_TICKS:  holdoff_ticks_reg <= cfg_data;
                REG_MAX_DISTANCE:   max_distance_reg <= cfg_data[DIST_W-1:0];
                REG_ALARM_DISTANCE: alarm_distance_reg <= cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // phase sequencer, advanced once per tick as it leaves the input register
    always_comb begin
        pt_inc = pt_reg + 20'd1;
        cnt_inc = cnt_reg + COUNT_BITS'(1);
        phase_next = phase_reg;
        pt_next = pt_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        trig_c = 1'b0;
        done_c = 1'b0;
        unique case (phase_reg)
            PH_TRIGGER: begin
                trig_c = 1'b1;
                // a zero setting still gives one tick of trigger, since any count meets it
                if (pt_inc >= trigger_ticks_reg || pt_inc == '0) begin
                    phase_next = PH_WAIT;
                    pt_next = '0;
                end else begin
                    pt_next = pt_inc;
                end
            end
            PH_WAIT: begin
                if (echo_reg) begin
                    cnt_next = COUNT_BITS'(1);
                    phase_next = PH_COUNT;
                end
            end
            PH_COUNT: begin
                if (echo_reg) begin
                    cnt_next = cnt_inc;
                    if (cnt_inc == '0) begin
                        ovf_next = 1'b1;
                    end
                end else begin
                    done_c = 1'b1;
                    cnt_next = '0;
                    ovf_next = 1'b0;
                    pt_next = '0;
                    phase_next = (holdoff_ticks_reg == '0) ? PH_TRIGGER : PH_HOLDOFF;
                end
            end
            PH_HOLDOFF: begin
                if (pt_inc >= holdoff_ticks_reg || pt_inc == '0) begin
                    phase_next = PH_TRIGGER;
                    pt_next = '0;
                end else begin
                    pt_next = pt_inc;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TRIGGER;
            pt_reg <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (st_en) begin
            phase_reg <= phase_next;
            pt_reg <= pt_next;
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

    // stage 2: scale by 17 and flag counts whose distance saturates
    always_comb begin
        c_low = X_W'(CNT_LOW_W'(cnt1_reg));
        s2_next.trig = trig1_reg;
        s2_next.done = done1_reg;
        s2_next.ovf = ovf1_reg;
        s2_next.sat = CNT_EXT_W'(cnt1_reg) >= SAT_COUNT;
        s2_next.x = (c_low << 4) + c_low;
    end

    // stage 3: divide by 1000 through the reciprocal
    always_comb begin
        prod_1000 = 43'(s2_reg.x) * 43'(RECIP_1000);
        s3_next.trig = s2_reg.trig;
        s3_next.done = s2_reg.done;
        s3_next.ovf = s2_reg.ovf;
        s3_next.dist_cm = s2_reg.sat ? DIST_MAX : prod_1000[41:31];
    end

    // stage 4: limit compares and the quotients by 100 and by 10
    always_comb begin
        prod_100 = 24'(s3_reg.dist_cm) * 24'(RECIP_100);
        prod_10 = 27'(s3_reg.dist_cm) * 27'(RECIP_10);
        s4_next.trig = s3_reg.trig;
        s4_next.done = s3_reg.done;
        // a saturated distance is 2047 and so always meets the limit
        s4_next.over = s3_reg.dist_cm >= max_distance_reg || s3_reg.ovf;
        s4_next.alarm = !s3_reg.ovf && s3_reg.dist_cm < alarm_distance_reg;
        s4_next.dist_cm = s3_reg.dist_cm;
        s4_next.q100 = prod_100[23:19];
        s4_next.q10 = prod_10[26:19];
    end

    // stage 5: reduce the quotients to digits and pack the result
    always_comb begin
        if (s4_reg.q100 >= 5'd20) begin
            dig_h = DIGIT_W'(s4_reg.q100 - 5'd20);
        end else if (s4_reg.q100 >= 5'd10) begin
            dig_h = DIGIT_W'(s4_reg.q100 - 5'd10);
        end else begin
            dig_h = DIGIT_W'(s4_reg.q100);
        end
        q10_x10 = (DIST_W'(s4_reg.q10) << 3) + (DIST_W'(s4_reg.q10) << 1);
        dig_o = DIGIT_W'(s4_reg.dist_cm - q10_x10);
        prod_t = 16'(s4_reg.q10) * 16'(RECIP_10_SMALL);
        tens_q = prod_t[15:11];
        tq_x10 = (8'(tens_q) << 3) + (8'(tens_q) << 1);
        dig_t = DIGIT_W'(s4_reg.q10 - tq_x10);
        tdata_next = '0;
        tdata_next[0] = s4_reg.trig;
        // zero every reading field on ticks without a completed measurement
        if (s4_reg.done) begin
            tdata_next[11:1] = s4_reg.dist_cm;
            tdata_next[15:12] = dig_h;
            tdata_next[19:16] = dig_t;
            tdata_next[23:20] = dig_o;
            tdata_next[24] = s4_reg.over;
            tdata_next[25] = s4_reg.alarm;
        end
    end

    // valid bits: each stage loads from the one before whenever it is ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy0) v0_reg <= s_tvalid;
            if (rdy1) v1_reg <= v0_reg;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // payloads: load with the request, hold while stalled
    always_ff @(posedge aclk) begin
        if (rdy0 && s_tvalid) begin
            echo_reg <= s_tdata[0];
        end
        if (st_en) begin
            trig1_reg <= trig_c;
            done1_reg <= done_c;
            cnt1_reg <= cnt_reg;
            ovf1_reg <= ovf_reg;
        end
        if (rdy2 && v1_reg) s2_reg <= s2_next;
        if (rdy3 && v2_reg) s3_reg <= s3_next;
        if (rdy4 && v3_reg) s4_reg <= s4_next;
        if (rdy5 && v4_reg) begin
            tdata_reg <= tdata_next;
            tuser_reg <= s4_reg.done;
        end
    end

    assign m_tdata = tdata_reg;
    assign m_tuser = tuser_reg;
    assign m_tvalid = v5_reg;

    // the echo counter only holds a value while a measurement is in progress
    a_count_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_TRIGGER || phase_reg == PH_HOLDOFF || phase_reg == PH_WAIT)
        |-> (cnt_reg == '0 && !ovf_reg))
        else $error("echo counter not cleared outside the count phase");

    // the phase tick counter is only live in trigger and holdoff
    a_ticks_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_WAIT || phase_reg == PH_COUNT) |-> pt_reg == '0)
        else $error("phase tick counter not cleared");

    // a tick without a completed measurement carries no reading
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tdata[M_DATA_W-1:1] == '0)
        else $error("reading fields set on a tick without a measurement");

    // the digit split never leaves the decimal range
    a_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:12] < 4'd10 && m_tdata[19:16] < 4'd10
                      && m_tdata[23:20] < 4'd10))
        else $error("digit out of range");

    // a measurement completes only with the trigger released
    a_done_no_trig: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> !m_tdata[0])
        else $error("trigger high on a completed measurement");

endmodule

`default_nettype wire
